// ===== src/pvca_pkg.sv =====
// types and constants shared by the voxel color accumulator modules
// no dependencies
package pvca_pkg;

   localparam int AXIS_CELLS = 32;
   localparam int POS_BITS = 24;
   localparam int COLOR_BITS = 16;
   localparam int CFG_IDX_BITS = 3;
   localparam int CFG_DATA_BITS = 24;
   localparam int CELL_FIELD_BITS = 6;
   localparam int OUT_CELL_BITS = 5;
   localparam int OUT_SUM_BITS = 24;
   localparam int VIDX_BITS = 15;
   localparam int ONE_Q12 = 4096;
   localparam int SIZE_BITS = POS_BITS + 1;
   localparam int NUMER_BITS = SIZE_BITS + CELL_FIELD_BITS + 1;
   localparam int DIV_CNT_BITS = 6;

   localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_X = 3'd0;
   localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_Y = 3'd1;
   localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_Z = 3'd2;
   localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_X = 3'd3;
   localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Y = 3'd4;
   localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_Z = 3'd5;
   localparam logic [CFG_IDX_BITS-1:0] CFG_CELLS = 3'd6;

   localparam logic [1:0] CMD_ACCUM = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_DONE,
      ST_MEM_READ,
      ST_MEM_WAIT,
      ST_MEM_WRITE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic clr_write;
      logic capture;
      logic div_load;
      logic div_step;
      logic div_store;
      logic mem_read;
      logic mem_write;
      logic out_load;
   } ctrl_type;

   typedef struct packed {
      logic clr_last;
      logic is_accum;
      logic ok;
      logic div_last;
      logic axis_last;
   } status_type;

endpackage

// ===== src/point_voxel_color_accumulator.sv =====
// top level of the voxel color accumulator
// depends on pvca_pkg, pvca_ctrl and pvca_datapath
//
// usage: one request word on req_* (valid/stall) gives one response word on
// rsp_* (valid/stall). cmd 0 bins a point into the box grid and adds its
// color to that voxel with saturation; cmd 1 returns a voxel clamped to 1.0
// and writes the clamped value back; cmd 2 zeroes a voxel.
// configuration registers on csr_* are to be written by the user only while the
// block is idle; the block itself does not enforce this. accumulate runs three
// serial divisions, one quotient bit per cycle, then a memory read-modify-write;
// read and clear do only the read-modify-write, and a point outside the box or
// a voxel index outside the grid goes straight to the response.
// one word is in flight at a time; req_stall is high while it is worked on and
// the next word can be taken in the cycle after the response is loaded.
// after reset the voxel memories are cleared one entry per cycle, all
// AXIS_CELLS**3 entries (32768 at the default), with req_stall high.
// a stalled response holds rsp_* steady; only the next response load waits.
module point_voxel_color_accumulator #(
   parameter int ACC_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [pvca_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [pvca_pkg::CFG_DATA_BITS-1:0]    csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_cmd,
   input  logic signed [pvca_pkg::POS_BITS-1:0]  req_point_x,
   input  logic signed [pvca_pkg::POS_BITS-1:0]  req_point_y,
   input  logic signed [pvca_pkg::POS_BITS-1:0]  req_point_z,
   input  logic [pvca_pkg::COLOR_BITS-1:0]       req_color_red,
   input  logic [pvca_pkg::COLOR_BITS-1:0]       req_color_green,
   input  logic [pvca_pkg::COLOR_BITS-1:0]       req_color_blue,
   input  logic [pvca_pkg::VIDX_BITS-1:0]        req_voxel_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_inside_res,
   output logic [pvca_pkg::OUT_CELL_BITS-1:0]    rsp_cell_x,
   output logic [pvca_pkg::OUT_CELL_BITS-1:0]    rsp_cell_y,
   output logic [pvca_pkg::OUT_CELL_BITS-1:0]    rsp_cell_z,
   output logic [pvca_pkg::OUT_SUM_BITS-1:0]     rsp_sum_red,
   output logic [pvca_pkg::OUT_SUM_BITS-1:0]     rsp_sum_green,
   output logic [pvca_pkg::OUT_SUM_BITS-1:0]     rsp_sum_blue
);
   import pvca_pkg::*;

   ctrl_type   ctrl;
   status_type stat;

   pvca_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .ctrl(ctrl)
   );

   pvca_datapath #(.ACC_BITS(ACC_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_cmd(req_cmd), .req_point_x(req_point_x), .req_point_y(req_point_y),
      .req_point_z(req_point_z), .req_color_red(req_color_red),
      .req_color_green(req_color_green), .req_color_blue(req_color_blue),
      .req_voxel_index(req_voxel_index),
      .rsp_inside_res(rsp_inside_res), .rsp_cell_x(rsp_cell_x),
      .rsp_cell_y(rsp_cell_y), .rsp_cell_z(rsp_cell_z),
      .rsp_sum_red(rsp_sum_red), .rsp_sum_green(rsp_sum_green),
      .rsp_sum_blue(rsp_sum_blue)
   );
endmodule

// ===== src/pvca_ctrl.sv =====
// controller state machine for the voxel color accumulator
// depends on pvca_pkg
module pvca_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pvca_pkg::status_type   stat,
   output pvca_pkg::ctrl_type     ctrl
);
   import pvca_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (stat.clr_last) state_in = ST_IDLE;
         ST_IDLE:      if (req_valid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (!stat.ok) state_in = ST_OUT;
            else if (stat.is_accum) state_in = ST_DIV_LOAD;
            else state_in = ST_MEM_READ;
         end
         ST_DIV_LOAD:  state_in = ST_DIV_STEP;
         ST_DIV_STEP:  if (stat.div_last) state_in = ST_DIV_DONE;
         ST_DIV_DONE:  state_in = stat.axis_last ? ST_MEM_READ : ST_DIV_LOAD;
         ST_MEM_READ:  state_in = ST_MEM_WAIT;
         ST_MEM_WAIT:  state_in = ST_MEM_WRITE;
         ST_MEM_WRITE: state_in = ST_OUT;
         ST_OUT:       if (!valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      valid_in = valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR:     ctrl.clr_write = 1'b1;
         ST_IDLE:      ctrl.capture = req_valid;
         ST_DIV_LOAD:  ctrl.div_load = 1'b1;
         ST_DIV_STEP:  ctrl.div_step = 1'b1;
         ST_DIV_DONE:  ctrl.div_store = 1'b1;
         ST_MEM_READ:  ctrl.mem_read = 1'b1;
         ST_MEM_WRITE: ctrl.mem_write = 1'b1;
         ST_OUT: begin
            if (!valid_ff || !rsp_stall) begin
               ctrl.out_load = 1'b1;
               valid_in = 1'b1;
            end
         end
         default: ctrl = '0;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

   a_no_load_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !ctrl.out_load) else $error("result overwritten");
   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.capture |=> (state_ff == ST_CHECK)) else $error("capture outside idle");
   a_clear_before_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall) else $error("accept during clear");
endmodule

// ===== src/pvca_datapath.sv =====
// datapath: box test, serial divider, voxel memories and result register
// depends on pvca_pkg
module pvca_datapath #(
   parameter int ACC_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pvca_pkg::ctrl_type                    ctrl,
   output pvca_pkg::status_type                  stat,
   input  logic                                  csr_write,
   input  logic [pvca_pkg::CFG_IDX_BITS-1:0]     csr_index,
   input  logic [pvca_pkg::CFG_DATA_BITS-1:0]    csr_data,
   input  logic [1:0]                            req_cmd,
   input  logic signed [pvca_pkg::POS_BITS-1:0]  req_point_x,
   input  logic signed [pvca_pkg::POS_BITS-1:0]  req_point_y,
   input  logic signed [pvca_pkg::POS_BITS-1:0]  req_point_z,
   input  logic [pvca_pkg::COLOR_BITS-1:0]       req_color_red,
   input  logic [pvca_pkg::COLOR_BITS-1:0]       req_color_green,
   input  logic [pvca_pkg::COLOR_BITS-1:0]       req_color_blue,
   input  logic [pvca_pkg::VIDX_BITS-1:0]        req_voxel_index,
   output logic                                  rsp_inside_res,
   output logic [pvca_pkg::OUT_CELL_BITS-1:0]    rsp_cell_x,
   output logic [pvca_pkg::OUT_CELL_BITS-1:0]    rsp_cell_y,
   output logic [pvca_pkg::OUT_CELL_BITS-1:0]    rsp_cell_z,
   output logic [pvca_pkg::OUT_SUM_BITS-1:0]     rsp_sum_red,
   output logic [pvca_pkg::OUT_SUM_BITS-1:0]     rsp_sum_green,
   output logic [pvca_pkg::OUT_SUM_BITS-1:0]     rsp_sum_blue
);
   import pvca_pkg::*;

   localparam int CB = $clog2(AXIS_CELLS);
   localparam int AB = 3 * CB;
   localparam int DEPTH = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;
   localparam int CNT_BITS = $clog2(AXIS_CELLS + 1);
   localparam logic [ACC_BITS-1:0] ACC_MAX = '1;
   localparam logic [ACC_BITS-1:0] ONE = ACC_BITS'(ONE_Q12);

   // configuration
   logic signed [POS_BITS-1:0] min_ff [3];
   logic signed [POS_BITS-1:0] max_ff [3];
   logic [3*CELL_FIELD_BITS-1:0] cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            min_ff[i] <= '0;
            max_ff[i] <= '0;
         end
         cells_ff <= 18'd82053;
      end else if (csr_write) begin
         case (csr_index)
            CFG_MIN_X: min_ff[0] <= csr_data;
            CFG_MIN_Y: min_ff[1] <= csr_data;
            CFG_MIN_Z: min_ff[2] <= csr_data;
            CFG_MAX_X: max_ff[0] <= csr_data;
            CFG_MAX_Y: max_ff[1] <= csr_data;
            CFG_MAX_Z: max_ff[2] <= csr_data;
            CFG_CELLS: cells_ff <= csr_data[3*CELL_FIELD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective cell counts
   logic [CNT_BITS-1:0] count [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic [CELL_FIELD_BITS-1:0] n;
         n = cells_ff[a*CELL_FIELD_BITS +: CELL_FIELD_BITS];
         if (n == '0) count[a] = CNT_BITS'(1);
         else if ({1'b0, n} > (CELL_FIELD_BITS+1)'(AXIS_CELLS)) count[a] = CNT_BITS'(AXIS_CELLS);
         else count[a] = CNT_BITS'(n);
      end
   end

   // captured request
   logic [1:0] cmd_ff;
   logic signed [POS_BITS-1:0] pt_ff [3];
   logic [COLOR_BITS-1:0] col_ff [3];
   logic [VIDX_BITS-1:0] vidx_ff;

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_cmd;
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
         col_ff[0] <= req_color_red;
         col_ff[1] <= req_color_green;
         col_ff[2] <= req_color_blue;
         vidx_ff <= req_voxel_index;
      end
   end

   // inside test and address decode
   logic in_box;
   logic addr_ok;
   logic [CB-1:0] dec [3];
   always_comb begin
      in_box = 1'b1;
      for (int a = 0; a < 3; a++)
         if (pt_ff[a] < min_ff[a] || pt_ff[a] > max_ff[a]) in_box = 1'b0;
      addr_ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         dec[a] = CB'(({{(32-VIDX_BITS){1'b0}}, vidx_ff} >> (a*CB)) % AXIS_CELLS);
         if (CNT_BITS'(dec[a]) >= count[a]) addr_ok = 1'b0;
      end
   end

   assign stat.is_accum = (cmd_ff == CMD_ACCUM);
   assign stat.ok = (cmd_ff == CMD_ACCUM) ? in_box :
                    ((cmd_ff == CMD_READ || cmd_ff == CMD_CLEAR) && addr_ok);

   // restoring divider, one quotient bit per cycle, one axis at a time
   logic [1:0] axis_ff;
   logic [DIV_CNT_BITS-1:0] step_ff;
   logic [NUMER_BITS-1:0] numer_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [SIZE_BITS:0] rem_ff;
   logic [CB-1:0] cell_ff [3];
   logic [SIZE_BITS:0] rem_sh;
   logic signed [SIZE_BITS-1:0] size_s, diff_s;

   always_comb begin
      size_s = SIZE_BITS'(max_ff[axis_ff]) - SIZE_BITS'(min_ff[axis_ff]);
      diff_s = SIZE_BITS'(pt_ff[axis_ff]) - SIZE_BITS'(min_ff[axis_ff]);
      rem_sh = {rem_ff[SIZE_BITS-1:0], numer_ff[NUMER_BITS-1]};
   end

   assign stat.div_last = (step_ff == DIV_CNT_BITS'(NUMER_BITS - 1));
   assign stat.axis_last = (axis_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (ctrl.capture) axis_ff <= 2'd0;
      else if (ctrl.div_store) axis_ff <= axis_ff + 2'd1;
      if (ctrl.div_load) begin
         step_ff <= '0;
         numer_ff <= NUMER_BITS'(diff_s) * NUMER_BITS'(count[axis_ff]);
         size_ff <= size_s;
         rem_ff <= '0;
      end else if (ctrl.div_step) begin
         step_ff <= step_ff + 1'b1;
         if (rem_sh >= {1'b0, size_ff}) begin
            rem_ff <= rem_sh - {1'b0, size_ff};
            numer_ff <= {numer_ff[NUMER_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            numer_ff <= {numer_ff[NUMER_BITS-2:0], 1'b0};
         end
      end
      if (ctrl.div_store) begin
         if (size_ff == '0) cell_ff[axis_ff] <= '0;
         else if (numer_ff >= NUMER_BITS'(count[axis_ff]))
            cell_ff[axis_ff] <= CB'(count[axis_ff] - 1'b1);
         else cell_ff[axis_ff] <= CB'(numer_ff);
      end
   end

   // voxel memories with clearing sweep
   logic [AB-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else if (ctrl.clr_write) clr_addr_ff <= clr_addr_ff + 1'b1;
   end
   assign stat.clr_last = (clr_addr_ff == AB'(DEPTH - 1));

   logic [CB-1:0] use_cell [3];
   always_comb begin
      for (int a = 0; a < 3; a++)
         use_cell[a] = stat.is_accum ? cell_ff[a] : dec[a];
   end
   logic [AB-1:0] addr;
   assign addr = {use_cell[2], use_cell[1], use_cell[0]};

   logic [ACC_BITS-1:0] mem_r [DEPTH];
   logic [ACC_BITS-1:0] mem_g [DEPTH];
   logic [ACC_BITS-1:0] mem_b [DEPTH];
   logic [ACC_BITS-1:0] rd_ff [3];
   logic [ACC_BITS-1:0] nv [3];
   logic [ACC_BITS-1:0] nv_ff [3];
   logic [AB-1:0] wr_addr;
   logic wr_en;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [ACC_BITS:0] s;
         s = {1'b0, rd_ff[c]} + (ACC_BITS+1)'(col_ff[c]);
         case (cmd_ff)
            CMD_ACCUM: nv[c] = s[ACC_BITS] ? ACC_MAX : s[ACC_BITS-1:0];
            CMD_READ:  nv[c] = (rd_ff[c] > ONE) ? ONE : rd_ff[c];
            default:   nv[c] = '0;
         endcase
      end
   end

   assign wr_en = ctrl.clr_write | ctrl.mem_write;
   assign wr_addr = ctrl.clr_write ? clr_addr_ff : addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_r[wr_addr] <= ctrl.clr_write ? '0 : nv[0];
         mem_g[wr_addr] <= ctrl.clr_write ? '0 : nv[1];
         mem_b[wr_addr] <= ctrl.clr_write ? '0 : nv[2];
      end
      if (ctrl.mem_read) begin
         rd_ff[0] <= mem_r[addr];
         rd_ff[1] <= mem_g[addr];
         rd_ff[2] <= mem_b[addr];
      end
      if (ctrl.mem_write) begin
         for (int c = 0; c < 3; c++) nv_ff[c] <= nv[c];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_inside_res <= stat.ok;
         if (stat.is_accum && !stat.ok) begin
            rsp_cell_x <= '0;
            rsp_cell_y <= '0;
            rsp_cell_z <= '0;
         end else if (cmd_ff == CMD_ACCUM || cmd_ff == CMD_READ || cmd_ff == CMD_CLEAR) begin
            rsp_cell_x <= OUT_CELL_BITS'(stat.is_accum ? cell_ff[0] :
                          (({{(32-VIDX_BITS){1'b0}}, vidx_ff}) % AXIS_CELLS));
            rsp_cell_y <= OUT_CELL_BITS'(stat.is_accum ? cell_ff[1] :
                          ((({{(32-VIDX_BITS){1'b0}}, vidx_ff}) >> CB) % AXIS_CELLS));
            rsp_cell_z <= OUT_CELL_BITS'(stat.is_accum ? cell_ff[2] :
                          (({{(32-VIDX_BITS){1'b0}}, vidx_ff}) >> (2*CB)));
         end else begin
            rsp_cell_x <= '0;
            rsp_cell_y <= '0;
            rsp_cell_z <= '0;
         end
         rsp_sum_red   <= stat.ok ? OUT_SUM_BITS'(nv_ff[0]) : '0;
         rsp_sum_green <= stat.ok ? OUT_SUM_BITS'(nv_ff[1]) : '0;
         rsp_sum_blue  <= stat.ok ? OUT_SUM_BITS'(nv_ff[2]) : '0;
      end
   end

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctrl.clr_write, ctrl.mem_read, ctrl.mem_write, ctrl.div_step, ctrl.out_load}))
      else $error("conflicting datapath commands");
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_write && stat.is_accum |-> (CNT_BITS'(cell_ff[0]) < count[0]))
      else $error("x cell out of range");
   a_sat: assert property (@(posedge clock) disable iff (reset)
      ctrl.mem_write && (cmd_ff == CMD_READ) |-> (nv[0] <= ONE))
      else $error("read not clamped");
endmodule
